@@ src/rud_pkg.sv @@
package rud_pkg;

  // width of the dividend, divisor, quotient and remainder fields on the ports
  localparam int DATA_W = 64;

  // default operand width
  localparam int WIDTH_DEFAULT = 64;

  // request payload
  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } rud_in_t;

  // result payload
  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
  } rud_out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } rud_state_t;

endpackage

@@ src/restoring_unsigned_divider_core.sv @@
// Unsigned restoring divider. A request carries a dividend and a divisor; only
// their low WIDTH bits are used. The result gives quotient and remainder,
// zero-extended to the port width, and a divide_by_zero flag; a zero divisor
// yields an all-ones quotient and the dividend as remainder. One shared
// WIDTH+1 bit subtract-and-compare unit produces one quotient bit per cycle
// in ST_RUN; after WIDTH bits the sequencer waits in ST_HOLD until the
// output register is free, then loads it and sets out_valid. A new request
// is taken from the cycle after the result is loaded. in_ready is high only
// in ST_IDLE, not while a division runs or waits in ST_HOLD; a finished
// result waiting in the output register does not block the next request.
module restoring_unsigned_divider_core #(
  parameter int WIDTH = rud_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rud_pkg::rud_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rud_pkg::rud_out_t out_data
);
  import rud_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  rud_state_t state, state_next;

  logic [WIDTH-1:0] rem, rem_next;
  logic [WIDTH-1:0] quo, quo_next;
  logic [WIDTH-1:0] den;
  logic             dbz;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic             in_fire;
  logic             out_free;
  logic             load_out;
  logic             last_step;
  logic [WIDTH:0]   partial;
  logic [WIDTH+1:0] diff;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign last_step = (cnt == CNT_W'(WIDTH - 1));

  // shared shift-subtract unit
  assign partial = {rem, quo[WIDTH-1]};
  assign diff    = {1'b0, partial} - {2'b00, den};

  // sequencer
  always_comb begin
    state_next = state;
    rem_next   = rem;
    quo_next   = quo;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rem_next   = '0;
          quo_next   = in_data.dividend[WIDTH-1:0];
          cnt_next   = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // restore when the trial subtraction borrows
        if (diff[WIDTH+1]) begin
          rem_next = partial[WIDTH-1:0];
          quo_next = {quo[WIDTH-2:0], 1'b0};
        end else begin
          rem_next = diff[WIDTH-1:0];
          quo_next = {quo[WIDTH-2:0], 1'b1};
        end
        cnt_next = cnt + 1'b1;
        if (last_step) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rem <= rem_next;
    quo <= quo_next;
    if (in_fire) begin
      den <= in_data.divisor[WIDTH-1:0];
      dbz <= (in_data.divisor[WIDTH-1:0] == '0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.quotient       <= DATA_W'(quo);
      out_data.remainder      <= DATA_W'(rem);
      out_data.divide_by_zero <= dbz;
    end
  end

endmodule

@@ src/rud_checker.sv @@
module rud_checker #(
  parameter int WIDTH = rud_pkg::WIDTH_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rud_pkg::rud_out_t out_data
);
  import rud_pkg::*;

  localparam logic [DATA_W-1:0] QMAX = DATA_W'({WIDTH{1'b1}});

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // accepted request keeps the divider busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while dividing");

  // zero divisor gives all-ones quotient
  a_dbz_quo: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divide_by_zero |-> out_data.quotient == QMAX)
    else $error("bad quotient on divide by zero");

  // nothing above the operand width
  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.quotient & ~QMAX) == '0 && (out_data.remainder & ~QMAX) == '0)
    else $error("result bits above width");

endmodule

bind restoring_unsigned_divider_core rud_checker #(.WIDTH(WIDTH)) u_rud_checker (.*);
